// ----- rtl/ialu_pkg.sv -----
// Shared operation codes, status codes and the per-stage record of the ALU pipeline.
package ialu_pkg;

   localparam logic [3:0] OP_ADD  = 4'd1;
   localparam logic [3:0] OP_SUB  = 4'd2;
   localparam logic [3:0] OP_MUL  = 4'd3;
   localparam logic [3:0] OP_DIV  = 4'd4;
   localparam logic [3:0] OP_REM  = 4'd5;
   localparam logic [3:0] OP_SQR  = 4'd6;
   localparam logic [3:0] OP_CUBE = 4'd7;
   localparam logic [3:0] OP_SQRT = 4'd8;
   localparam logic [3:0] OP_CBRT = 4'd9;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_DIVZ   = 2'd1;
   localparam logic [1:0] ST_NEGRT  = 2'd2;

   // Control that travels with every item down the row of cells.
   typedef struct packed {
      logic       valid;
      logic [3:0] kind;
      logic       neg_a;
      logic       neg_b;
      logic       b_zero;
   } ctl_type;

endpackage

// ----- rtl/integer_alu_with_roots_core.sv -----
// Top level of the integer ALU: front stage, row of arithmetic cells and output skid stage.
//
// Use: present an operation on req_kind, req_operand_a and req_operand_b with
// req_valid; the beat is taken when req_ready is high. Each input beat gives
// exactly one result beat on rsp_value and rsp_status, in input order.
// From input beat to result beat a result passes, in order, the front stage
// with the first products, the second product stage, one cell per quotient
// bit and the output stage with the sign fix-up.
// The row of cells is one pipeline that advances as a whole, so one operation
// enters every cycle unless the row holds; the divider cell row (one cell per
// quotient bit) sets the latency.
// When the receiver stalls, the finished result waits in the skid register and
// the row keeps moving until its last stage is full, then req_ready drops and
// the whole row holds. Synchronous reset empties every stage; no results are
// pending after it. Add, sub, multiply, square and cube wrap; divide and
// remainder by zero give status 1, square root of a negative value status 2,
// both with value 0.
module integer_alu_with_roots_core #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [3:0]                    req_kind,
   input  logic signed [DATA_WIDTH-1:0]  req_operand_a,
   input  logic signed [DATA_WIDTH-1:0]  req_operand_b,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [DATA_WIDTH-1:0]  rsp_value,
   output logic [1:0]                    rsp_status
);
   import ialu_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int CW = W + 2;

   // Front stage: magnitudes and the fast operations' partial products.
   ctl_type        c0_ff;
   logic [W-1:0]   a0_ff, ma0_ff, mb0_ff, sum0_ff, mul0_ff, sqr0_ff;
   // Second stage: cube's second product and selection of the fast result.
   ctl_type        c1_ff;
   logic [W-1:0]   ma1_ff, mb1_ff, fast1_ff;

   logic           advance;
   logic           last_full;
   logic           skid_valid_ff;
   logic [W-1:0]   skid_value_ff;
   logic [1:0]     skid_status_ff;

   ctl_type        ctl_c [W+1];
   logic [W-1:0]   ma_c [W+1];
   logic [W-1:0]   mb_c [W+1];
   logic [W-1:0]   quo_c [W+1];
   logic [W:0]     rem_c [W+1];
   logic [W-1:0]   sqr_c [W+1];
   logic [CW-1:0]  sqm_c [W+1];
   logic [W-1:0]   cby_c [W+1];
   logic [CW-1:0]  cbm_c [W+1];
   logic [W-1:0]   fast_c [W+1];

   ctl_type        cl;
   logic [W-1:0]   val_in;
   logic [1:0]     st_in;
   logic [W-1:0]   mag_root;

   // The row holds only when its last cell is full, the skid stage is occupied
   // and the receiver is not taking the waiting beat.
   assign last_full = ctl_c[W].valid;
   assign advance   = !(last_full && skid_valid_ff && !rsp_ready);
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_ff.valid <= 1'b0;
         c1_ff.valid <= 1'b0;
      end else if (advance) begin
         c0_ff.valid <= req_valid;
         c1_ff.valid <= c0_ff.valid;
      end
      if (advance) begin
         c0_ff.kind   <= req_kind;
         c0_ff.neg_a  <= req_operand_a[W-1];
         c0_ff.neg_b  <= req_operand_b[W-1];
         c0_ff.b_zero <= (req_operand_b == '0);
         a0_ff   <= req_operand_a;
         ma0_ff  <= req_operand_a[W-1] ? W'(-req_operand_a) : W'(req_operand_a);
         mb0_ff  <= req_operand_b[W-1] ? W'(-req_operand_b) : W'(req_operand_b);
         sum0_ff <= (req_kind == OP_SUB) ? W'(req_operand_a - req_operand_b)
                                         : W'(req_operand_a + req_operand_b);
         mul0_ff <= W'(req_operand_a * req_operand_b);
         sqr0_ff <= W'(req_operand_a * req_operand_a);
         c1_ff.kind   <= c0_ff.kind;
         c1_ff.neg_a  <= c0_ff.neg_a;
         c1_ff.neg_b  <= c0_ff.neg_b;
         c1_ff.b_zero <= c0_ff.b_zero;
         ma1_ff <= ma0_ff;
         mb1_ff <= mb0_ff;
         unique case (c0_ff.kind)
            OP_ADD, OP_SUB: fast1_ff <= sum0_ff;
            OP_MUL:         fast1_ff <= mul0_ff;
            OP_SQR:         fast1_ff <= sqr0_ff;
            OP_CUBE:        fast1_ff <= W'(sqr0_ff * a0_ff);
            default:        fast1_ff <= '0;
         endcase
      end
   end

   assign ctl_c[0]  = c1_ff;
   assign ma_c[0]   = ma1_ff;
   assign mb_c[0]   = mb1_ff;
   assign quo_c[0]  = '0;
   assign rem_c[0]  = '0;
   assign sqr_c[0]  = '0;
   assign sqm_c[0]  = '0;
   assign cby_c[0]  = '0;
   assign cbm_c[0]  = '0;
   assign fast_c[0] = fast1_ff;

   for (genvar i = 0; i < W; i++) begin : g_cell
      ialu_cell #(.DATA_WIDTH(W), .IDX(i)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .ctl_prev    (ctl_c[i]),
         .mag_a_prev  (ma_c[i]),
         .mag_b_prev  (mb_c[i]),
         .quo_prev    (quo_c[i]),
         .rem_prev    (rem_c[i]),
         .sq_res_prev (sqr_c[i]),
         .sq_rem_prev (sqm_c[i]),
         .cb_y_prev   (cby_c[i]),
         .cb_rem_prev (cbm_c[i]),
         .fast_prev   (fast_c[i]),
         .ctl_ff      (ctl_c[i+1]),
         .mag_a_ff    (ma_c[i+1]),
         .mag_b_ff    (mb_c[i+1]),
         .quo_ff      (quo_c[i+1]),
         .rem_ff      (rem_c[i+1]),
         .sq_res_ff   (sqr_c[i+1]),
         .sq_rem_ff   (sqm_c[i+1]),
         .cb_y_ff     (cby_c[i+1]),
         .cb_rem_ff   (cbm_c[i+1]),
         .fast_ff     (fast_c[i+1])
      );
   end

   // Result selection and sign fix-up at the end of the row.
   always_comb begin
      cl       = ctl_c[W];
      val_in   = '0;
      st_in    = ST_OK;
      mag_root = cby_c[W];
      unique case (cl.kind)
         OP_ADD, OP_SUB, OP_MUL, OP_SQR, OP_CUBE: val_in = fast_c[W];
         OP_DIV: begin
            if (cl.b_zero) st_in = ST_DIVZ;
            else val_in = (cl.neg_a != cl.neg_b) ? W'(-quo_c[W]) : quo_c[W];
         end
         OP_REM: begin
            if (cl.b_zero) st_in = ST_DIVZ;
            else val_in = cl.neg_a ? W'(-rem_c[W][W-1:0]) : rem_c[W][W-1:0];
         end
         OP_SQRT: begin
            if (cl.neg_a) st_in = ST_NEGRT;
            else val_in = sqr_c[W];
         end
         OP_CBRT: val_in = cl.neg_a ? W'(-mag_root) : mag_root;
         default: val_in = '0;
      endcase
   end

   // Skid stage: holds one finished result while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (!skid_valid_ff || rsp_ready) begin
         skid_valid_ff <= last_full;
      end
      if (!skid_valid_ff || rsp_ready) begin
         skid_value_ff  <= val_in;
         skid_status_ff <= st_in;
      end
   end

   assign rsp_valid  = skid_valid_ff;
   assign rsp_value  = skid_value_ff;
   assign rsp_status = skid_status_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("held result changed under stall");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DIVZ |-> rsp_value == '0)
      else $error("divide error with nonzero value");
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> last_full && skid_valid_ff)
      else $error("input stalled without full row");

endmodule

// ----- rtl/ialu_cell.sv -----
// One cell of the arithmetic row: a restoring divide step, a square-root step and a cube-root step.
module ialu_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int IDX        = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  ialu_pkg::ctl_type       ctl_prev,
   input  logic [DATA_WIDTH-1:0]   mag_a_prev,
   input  logic [DATA_WIDTH-1:0]   mag_b_prev,
   input  logic [DATA_WIDTH-1:0]   quo_prev,
   input  logic [DATA_WIDTH:0]     rem_prev,
   input  logic [DATA_WIDTH-1:0]   sq_res_prev,
   input  logic [DATA_WIDTH+1:0]   sq_rem_prev,
   input  logic [DATA_WIDTH-1:0]   cb_y_prev,
   input  logic [DATA_WIDTH+1:0]   cb_rem_prev,
   input  logic [DATA_WIDTH-1:0]   fast_prev,
   output ialu_pkg::ctl_type       ctl_ff,
   output logic [DATA_WIDTH-1:0]   mag_a_ff,
   output logic [DATA_WIDTH-1:0]   mag_b_ff,
   output logic [DATA_WIDTH-1:0]   quo_ff,
   output logic [DATA_WIDTH:0]     rem_ff,
   output logic [DATA_WIDTH-1:0]   sq_res_ff,
   output logic [DATA_WIDTH+1:0]   sq_rem_ff,
   output logic [DATA_WIDTH-1:0]   cb_y_ff,
   output logic [DATA_WIDTH+1:0]   cb_rem_ff,
   output logic [DATA_WIDTH-1:0]   fast_ff
);
   import ialu_pkg::*;

   localparam int W      = DATA_WIDTH;
   localparam int SQ_POS = W - 2 - 2 * (IDX / 2);
   localparam int CB_POS = ((W - 1) / 3) * 3 - 3 * (IDX / 3);
   localparam int CW     = W + 2;

   logic [W:0]     rem_sh;
   logic [W:0]     rem_sub;
   logic           sq_act;
   logic [1:0]     sq_pair;
   logic [CW-1:0]  sq_cur;
   logic [CW-1:0]  sq_try;
   logic           cb_act;
   logic [2:0]     cb_grp;
   logic [CW-1:0]  cb_cur;
   logic [CW-1:0]  cb_y2;
   logic [2*CW-1:0] cb_prod;
   logic [CW-1:0]  cb_b;

   logic [W-1:0]   quo_in;
   logic [W:0]     rem_in;
   logic [W-1:0]   sq_res_in;
   logic [CW-1:0]  sq_rem_in;
   logic [W-1:0]   cb_y_in;
   logic [CW-1:0]  cb_rem_in;

   // Divide: one quotient bit per cell, most significant first.
   always_comb begin
      rem_sh  = {rem_prev[W-1:0], mag_a_prev[W-1-IDX]};
      rem_sub = rem_sh - {1'b0, mag_b_prev};
      quo_in  = quo_prev;
      rem_in  = rem_sh;
      if (!rem_sub[W]) begin
         rem_in = rem_sub;
         quo_in[W-1-IDX] = 1'b1;
      end
   end

   // Square root: one result bit every second cell, digit pair taken from the top.
   always_comb begin
      sq_act    = (IDX % 2 == 0) && (SQ_POS >= 0);
      sq_pair   = (SQ_POS >= 0) ? mag_a_prev[SQ_POS[4+($clog2(W)>5 ? 1:0):0] +: 2] : 2'b00;
      sq_cur    = {sq_rem_prev[CW-3:0], sq_pair};
      sq_try    = {sq_res_prev, 2'b01};
      sq_res_in = sq_res_prev;
      sq_rem_in = sq_rem_prev;
      if (sq_act) begin
         sq_res_in = {sq_res_prev[W-2:0], 1'b0};
         sq_rem_in = sq_cur;
         if (sq_cur >= sq_try) begin
            sq_rem_in = sq_cur - sq_try;
            sq_res_in[0] = 1'b1;
         end
      end
   end

   // Cube root: one result bit every third cell; 3y(y+1)+1 against the next digit group.
   always_comb begin
      cb_act  = (IDX % 3 == 0) && (CB_POS >= 0);
      cb_grp  = 3'b000;
      for (int k = 0; k < 3; k++) begin
         if (CB_POS + k < W) cb_grp[k] = mag_a_prev[(CB_POS + k) % W];
      end
      cb_cur  = {cb_rem_prev[CW-4:0], cb_grp};
      cb_y2   = {1'b0, cb_y_prev, 1'b0};
      cb_prod = cb_y2 * (cb_y2 + CW'(1));
      cb_b    = CW'(3) * cb_prod[CW-1:0] + CW'(1);
      cb_y_in   = cb_y_prev;
      cb_rem_in = cb_rem_prev;
      if (cb_act) begin
         cb_y_in   = {cb_y_prev[W-2:0], 1'b0};
         cb_rem_in = cb_cur;
         if (cb_cur >= cb_b) begin
            cb_rem_in = cb_cur - cb_b;
            cb_y_in[0] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_ff.valid <= ctl_prev.valid;
      end
      if (advance) begin
         ctl_ff.kind   <= ctl_prev.kind;
         ctl_ff.neg_a  <= ctl_prev.neg_a;
         ctl_ff.neg_b  <= ctl_prev.neg_b;
         ctl_ff.b_zero <= ctl_prev.b_zero;
         mag_a_ff  <= mag_a_prev;
         mag_b_ff  <= mag_b_prev;
         quo_ff    <= quo_in;
         rem_ff    <= rem_in;
         sq_res_ff <= sq_res_in;
         sq_rem_ff <= sq_rem_in;
         cb_y_ff   <= cb_y_in;
         cb_rem_ff <= cb_rem_in;
         fast_ff   <= fast_prev;
      end
   end

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking bench for the integer ALU with exact square and cube roots.
module tb;
   import ialu_pkg::*;

   localparam int W = 32;
   localparam int LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [3:0] req_kind = OP_ADD;
   logic signed [W-1:0] req_operand_a = '0;
   logic signed [W-1:0] req_operand_b = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [W-1:0] rsp_value;
   logic [1:0] rsp_status;

   typedef struct {
      logic [W-1:0] value;
      logic [1:0]   status;
   } alu_result_type;

   class alu_scoreboard;
      alu_result_type pending[$];
      int errors = 0;

      function logic [W-1:0] isqrt(logic [W-1:0] n);
         logic [W-1:0] r;
         r = 0;
         for (int i = W/2 - 1; i >= 0; i--)
            if (64'((r | (1 << i))) * 64'((r | (1 << i))) <= 64'(n)) r = r | (1 << i);
         return r;
      endfunction

      function logic [W-1:0] icbrt(logic [W-1:0] n);
         logic [W-1:0] r;
         logic [63:0] t;
         r = 0;
         for (int i = 10; i >= 0; i--) begin
            t = 64'(r | (1 << i));
            if (t * t * t <= 64'(n)) r = r | (1 << i);
         end
         return r;
      endfunction

      function void note_operation(logic [3:0] kind, logic [W-1:0] a, logic [W-1:0] b);
         alu_result_type e;
         logic [W-1:0] ma, mb;
         e.value = 0;
         e.status = ST_OK;
         ma = a[W-1] ? -a : a;
         mb = b[W-1] ? -b : b;
         case (kind)
            OP_ADD: e.value = a + b;
            OP_SUB: e.value = a - b;
            OP_MUL: e.value = a * b;
            OP_DIV, OP_REM: begin
               if (b == 0) e.status = ST_DIVZ;
               else if (kind == OP_DIV) e.value = (a[W-1] != b[W-1]) ? -(ma / mb) : ma / mb;
               else e.value = a[W-1] ? -(ma % mb) : ma % mb;
            end
            OP_SQR: e.value = a * a;
            OP_CUBE: e.value = a * a * a;
            OP_SQRT: begin
               if (a[W-1]) e.status = ST_NEGRT;
               else e.value = isqrt(a);
            end
            OP_CBRT: e.value = a[W-1] ? -icbrt(ma) : icbrt(ma);
            default: ;
         endcase
         pending.push_back(e);
      endfunction

      function void check_result(logic [W-1:0] value, logic [1:0] status);
         alu_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result value %h status %0d", $time, value, status);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (value !== e.value) begin
            $display("%0t: value expected %h actual %h", $time, e.value, value);
            errors++;
         end
         if (status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, status);
            errors++;
         end
      endfunction
   endclass

   alu_scoreboard board = new();
   int send_idle = 0;
   int recv_stall = 0;
   bit long_hold = 0;
   int cycles = 0;

   integer_alu_with_roots_core #(.DATA_WIDTH(W)) uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Both sides are sampled at the edge, before the new drive values land.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_valid && req_ready)
         board.note_operation(req_kind, req_operand_a, req_operand_b);
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_value, rsp_status);
      if (cycles > LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Receiver: random stalls, or a long counted hold-off.
   always @(posedge clock) begin
      int hold_count;
      if (reset) rsp_ready <= 1'b0;
      else if (long_hold) begin
         hold_count = 0;
         rsp_ready <= 1'b0;
         while (hold_count < 300) begin
            @(posedge clock);
            hold_count++;
         end
         long_hold = 0;
         rsp_ready <= 1'b1;
      end else
         rsp_ready <= ($urandom_range(99) >= recv_stall);
   end

   function logic [W-1:0] pick_operand();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 0;
         4: return $urandom_range(20) - 10;
         5: return $urandom_range(70000);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_operation(logic [3:0] kind, logic [W-1:0] a, logic [W-1:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic go_quiet();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Extremes, every operation, zero divisors, negative roots, unused codes.
      send_operation(OP_ADD, 32'h7fff_ffff, 1);
      send_operation(OP_SUB, 32'h8000_0000, 1);
      send_operation(OP_MUL, 32'hffff_ffff, 32'h8000_0000);
      send_operation(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
      send_operation(OP_REM, 32'h8000_0000, 32'hffff_ffff);
      send_operation(OP_DIV, 7, 0);
      send_operation(OP_REM, -7, 0);
      send_operation(OP_DIV, -7, 2);
      send_operation(OP_REM, -7, 2);
      send_operation(OP_SQR, 32'h8000_0000, 0);
      send_operation(OP_CUBE, -1291, 5);
      send_operation(OP_SQRT, 32'h7fff_ffff, 0);
      send_operation(OP_SQRT, -1, 0);
      send_operation(OP_SQRT, 0, 0);
      send_operation(OP_CBRT, 32'h8000_0000, 0);
      send_operation(OP_CBRT, 32'h7fff_ffff, 0);
      send_operation(OP_CBRT, -27, 0);
      send_operation(4'd0, 5, 5);
      send_operation(4'd15, 32'hffff_ffff, 32'hffff_ffff);
      send_operation(4'd10, 1, 1);
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 63; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 63; end
            3: begin send_idle = 6; recv_stall = 6; end
            default: begin send_idle = 0; recv_stall = 0; long_hold = 1; end
         endcase
         for (int n = 0; n < 390; n++)
            send_operation(4'($urandom_range(15) < 14 ? $urandom_range(9, 1)
                                                      : $urandom_range(15)),
                           pick_operand(), pick_operand());
         if (phase == 1) go_quiet();
      end
      req_valid <= 1'b0;
      recv_stall = 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (2 * W + 10) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
